### hw/rtl/sm4_pkg.sv
// Shared constants, S-box table and round transform for the SM4 cipher unit.
package sm4_pkg;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 64;
    localparam int ROUND_COUNT = 32;
    localparam int KEY_DEPTH   = 32;
    localparam int KEY_IDX_W   = $clog2(KEY_DEPTH);
    localparam int REQ_W       = 2;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [REQ_W-1:0]     req_t;

    localparam req_t REQ_LOAD = 2'd0;
    localparam req_t REQ_ENC  = 2'd1;
    localparam req_t REQ_DEC  = 2'd2;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic word_t rotl(input word_t v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t t_transform(input word_t a);
        word_t b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

endpackage

### hw/rtl/sm4_block_cipher_unit.sv
// SM4 block cipher unit: round key table, round sequencer and result register.
// A block item passes through key fetch at the accepting edge, 32 rounds and the result load;
// a key load item gives no result. Items are not overlapped: the single shared round unit runs
// once per round, and req_stall holds new items until the current block has left ST_DONE.
// The next item is accepted while the previous result still waits in the output register.
// Reset clears control state; the round key table holds no defined value until loaded.
module sm4_block_cipher_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  sm4_pkg::req_t           req_type,
    input  sm4_pkg::key_idx_t       key_slot,
    input  sm4_pkg::word_t          key_word,
    input  logic [63:0]             block_high,
    input  logic [63:0]             block_low,
    input  logic                    end_of_message,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [63:0]             result_high,
    output logic [63:0]             result_low,
    output logic                    last_out
);
    import sm4_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    key_idx_t    round_reg, round_next;
    logic        dec_reg, dec_next;
    logic        last_reg, last_next;
    word_t       x0_reg, x1_reg, x2_reg, x3_reg;
    word_t       x0_next, x1_next, x2_next, x3_next;
    word_t       rk_reg;
    word_t       key_mem [KEY_DEPTH];
    logic        out_valid_reg, out_valid_next;
    logic [63:0] res_high_reg, res_low_reg;
    logic        res_last_reg;

    logic        accept;
    logic        is_block;
    logic        key_we;
    logic        out_free;
    logic        out_load;
    key_idx_t    rd_addr;
    key_idx_t    round_inc;
    word_t       new_word;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign is_block  = (req_type == REQ_ENC) || (req_type == REQ_DEC);
    assign key_we    = accept && (req_type == REQ_LOAD);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign round_inc = round_reg + key_idx_t'(1);
    assign new_word  = x0_reg ^ t_transform(x1_reg ^ x2_reg ^ x3_reg ^ rk_reg);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = (req_type == REQ_DEC) ? key_idx_t'(ROUND_COUNT - 1) : '0;
        end
        else
        begin
            rd_addr = round_inc ^ {KEY_IDX_W{dec_reg}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_slot] <= key_word;
        end
        rk_reg <= key_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        dec_next   = dec_reg;
        last_next  = last_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        x3_next    = x3_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_block)
                begin
                    state_next = ST_RUN;
                    round_next = '0;
                    dec_next   = (req_type == REQ_DEC);
                    last_next  = end_of_message;
                    x0_next    = block_high[63:32];
                    x1_next    = block_high[31:0];
                    x2_next    = block_low[63:32];
                    x3_next    = block_low[31:0];
                end
            end
            ST_RUN:
            begin
                x0_next    = x1_reg;
                x1_next    = x2_reg;
                x2_next    = x3_reg;
                x3_next    = new_word;
                round_next = round_inc;
                if (round_reg == key_idx_t'(ROUND_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        dec_reg   <= dec_next;
        last_reg  <= last_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        x3_reg    <= x3_next;
        if (out_load)
        begin
            res_high_reg <= {x3_reg, x2_reg};
            res_low_reg  <= {x1_reg, x0_reg};
            res_last_reg <= last_reg;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign result_high = res_high_reg;
    assign result_low  = res_low_reg;
    assign last_out    = res_last_reg;

endmodule

### tb/tb_sm4_block_cipher_unit.sv
// Self-checking testbench for the SM4 block cipher unit: round key loads, block items and unused request codes.
module tb_sm4_block_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sm4_pkg::*;

    localparam int          CIPHER_ROUNDS = 32;
    localparam int          PHASE_ITEMS   = 463;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam req_t        REQ_UNUSED    = 2'd3;

    localparam logic [7:0] SUBST_BYTES [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
        logic        last;
    } block_result_t;

    class sm4_scoreboard;
        word_t         round_key_mem [32];
        block_result_t pending_blocks [$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
            foreach (round_key_mem[i])
                round_key_mem[i] = '0;
        endfunction

        function word_t rot_left(word_t v, int unsigned n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function word_t round_mix(word_t a);
            word_t b;
            b = {SUBST_BYTES[a[31:24]], SUBST_BYTES[a[23:16]],
                 SUBST_BYTES[a[15:8]], SUBST_BYTES[a[7:0]]};
            return b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
        endfunction

        function block_result_t cipher_block(bit reverse_keys, logic [63:0] hi,
                                             logic [63:0] lo, logic eom);
            word_t         x [4];
            word_t         nx;
            word_t         rk;
            block_result_t r;
            x[0] = hi[63:32];
            x[1] = hi[31:0];
            x[2] = lo[63:32];
            x[3] = lo[31:0];
            for (int i = 0; i < CIPHER_ROUNDS; i++)
            begin
                rk   = round_key_mem[reverse_keys ? CIPHER_ROUNDS - 1 - i : i];
                nx   = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
                x[0] = x[1];
                x[1] = x[2];
                x[2] = x[3];
                x[3] = nx;
            end
            r.high = {x[3], x[2]};
            r.low  = {x[1], x[0]};
            r.last = eom;
            return r;
        endfunction

        function void note_request(req_t kind, key_idx_t slot, word_t kw,
                                   logic [63:0] hi, logic [63:0] lo, logic eom);
            if (kind == REQ_LOAD)
                round_key_mem[slot] = kw;
            else if (kind == REQ_ENC || kind == REQ_DEC)
                pending_blocks.push_back(cipher_block(kind == REQ_DEC, hi, lo, eom));
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo, logic last);
            block_result_t e;
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected result: result_high %h result_low %h last_out %b",
                       hi, lo, last);
                mismatches++;
                return;
            end
            e = pending_blocks.pop_front();
            if (hi !== e.high)
            begin
                $error("result_high mismatch: expected %h, got %h", e.high, hi);
                mismatches++;
            end
            if (lo !== e.low)
            begin
                $error("result_low mismatch: expected %h, got %h", e.low, lo);
                mismatches++;
            end
            if (last !== e.last)
            begin
                $error("last_out mismatch: expected %b, got %b", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        req_valid      = 1'b0;
    logic        req_stall;
    req_t        req_type       = REQ_LOAD;
    key_idx_t    key_slot       = '0;
    word_t       key_word       = '0;
    logic [63:0] block_high     = '0;
    logic [63:0] block_low      = '0;
    logic        end_of_message = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall      = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        last_out;

    sm4_scoreboard sb;
    int unsigned   idle_pct  = 0;
    int unsigned   stall_pct = 0;
    int unsigned   cycle_count = 0;

    sm4_block_cipher_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .key_slot       (key_slot),
        .key_word       (key_word),
        .block_high     (block_high),
        .block_low      (block_low),
        .end_of_message (end_of_message),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_high    (result_high),
        .result_low     (result_low),
        .last_out       (last_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(result_high, result_low, last_out);

    function automatic logic [63:0] pick_half();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic word_t pick_key_word();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_item(input req_t kind, input key_idx_t slot, input word_t kw,
                             input logic [63:0] hi, input logic [63:0] lo, input logic eom);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        req_type       <= kind;
        key_slot       <= slot;
        key_word       <= kw;
        block_high     <= hi;
        block_low      <= lo;
        end_of_message <= eom;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(kind, slot, kw, hi, lo, eom);
    endtask

    task automatic send_block(input req_t kind);
        send_item(kind, key_idx_t'($urandom), $urandom, pick_half(), pick_half(),
                  1'($urandom));
    endtask

    task automatic rekey_all();
        int unsigned stride;
        int unsigned offset;
        stride = 2 * $urandom_range(15) + 1;
        offset = $urandom_range(31);
        for (int i = 0; i < 32; i++)
            send_item(REQ_LOAD, key_idx_t'(i * stride + offset), pick_key_word(),
                      {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic run_random(input int quota);
        int          counted;
        int unsigned roll;
        counted = 0;
        while (counted < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
            begin
                rekey_all();
                counted += 32;
            end
            else if (roll < 5)
                send_item(REQ_UNUSED, key_idx_t'($urandom), $urandom, pick_half(),
                          pick_half(), 1'($urandom));
            else if (roll < 25)
            begin
                send_item(REQ_LOAD, key_idx_t'($urandom), pick_key_word(), pick_half(),
                          pick_half(), 1'($urandom));
                counted++;
            end
            else
            begin
                send_block(roll < 62 ? REQ_ENC : REQ_DEC);
                counted++;
            end
        end
    endtask

    initial
    begin
        int unsigned idle_by_phase  [4] = '{0, 66, 0, 21};
        int unsigned stall_by_phase [4] = '{0, 0, 66, 21};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every round key before any block reads one
        for (int i = 31; i >= 0; i--)
            send_item(REQ_LOAD, key_idx_t'(i), i == 0 ? 32'h0 : (i == 31 ? '1 : $urandom),
                      '0, '1, 1'(i));
        send_item(REQ_ENC, 5'd0, '0, '0, '0, 1'b0);
        send_item(REQ_ENC, '1, '1, '1, '1, 1'b1);
        send_item(REQ_DEC, 5'd0, '0, '0, '0, 1'b1);
        send_item(REQ_DEC, '1, '1, '1, '1, 1'b0);
        send_item(REQ_UNUSED, '1, '1, '1, '1, 1'b1);
        send_item(REQ_ENC, 5'd3, '0, '1, '0, 1'b1);
        send_item(REQ_DEC, 5'd7, '0, '0, '1, 1'b0);
        send_item(REQ_LOAD, 5'd5, 32'ha5a5_5a5a, '0, '0, 1'b0);
        send_item(REQ_UNUSED, 5'd0, '0, '0, '0, 1'b0);
        send_block(REQ_ENC);
        send_block(REQ_DEC);
        send_item(REQ_LOAD, 5'd0, '1, '1, '1, 1'b1);
        send_item(REQ_LOAD, 5'd31, '0, '0, '0, 1'b0);
        send_block(REQ_ENC);
        send_block(REQ_DEC);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            run_random(PHASE_ITEMS);
        end
        req_valid <= 1'b0;

        while (sb.pending_blocks.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_blocks.size() > 0)
        begin
            $error("%0d expected results never arrived", sb.pending_blocks.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_block_cipher_unit.sv
tb/tb_sm4_block_cipher_unit.sv
